>>> hw/rtl/tpd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the two-phase task dispatcher.
// No dependencies; every other file of the block imports this package.
package tpd_pkg;

    localparam int MAX_TASKS = 64;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int ADDR_W    = IDX_W + 1;
    localparam int TIME_W    = 32;
    localparam int DEPTH     = 2 * MAX_TASKS;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [TIME_W-1:0] t_time;
    typedef logic [1:0]        t_code;

    // request types
    localparam t_code REQ_ASK  = 2'd0;
    localparam t_code REQ_ACK  = 2'd1;
    localparam t_code REQ_DONE = 2'd2;

    // result codes
    localparam t_code RES_OK   = 2'd0;
    localparam t_code RES_NONE = 2'd1;
    localparam t_code RES_BUSY = 2'd2;
    localparam t_code RES_BAD  = 2'd3;

    // task status
    localparam t_code ST_UNSTARTED = 2'd0;
    localparam t_code ST_PENDING   = 2'd1;
    localparam t_code ST_FINISHED  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_MAP_CNT  = 2'd0;
    localparam logic [1:0] REG_RED_CNT  = 2'd1;
    localparam logic [1:0] REG_PARTS    = 2'd2;
    localparam logic [1:0] REG_TIMEOUT  = 2'd3;

    typedef struct packed {
        t_code status;
        t_time start;
    } t_entry;

    typedef struct packed {
        logic   we;
        t_addr  addr;
        t_entry data;
    } t_mem_wr;

    typedef struct packed {
        t_code req;
        logic  kind;
        t_idx  idx;
        t_time now;
    } t_request;

    typedef struct packed {
        t_code  code;
        logic   kind;
        t_idx   idx;
        t_count parts;
        logic   all_done;
    } t_result;

    // a count of zero acts as one, anything above the table size as the table size
    function automatic t_count clamp_count(input t_count c);
        t_count r;
        if (c == '0) begin
            r = t_count'(1);
        end else if (c > t_count'(MAX_TASKS)) begin
            r = t_count'(MAX_TASKS);
        end else begin
            r = c;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/tpd_task_ram.sv
`timescale 1ns / 1ps
// Task table memory: map entries in the lower half, reduce entries in the upper.
// One write and one registered read per cycle; per-entry valid bits give reset.
// Depends on tpd_pkg.
module tpd_task_ram (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tpd_pkg::t_addr  i_rd_addr,
    output tpd_pkg::t_entry o_rd_data,
    input  tpd_pkg::t_mem_wr i_wr
);
    import tpd_pkg::*;

    t_entry             mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    t_entry             r_rd;
    logic               r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rd <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    // an entry never written reads as unstarted with a zero start time
    assign o_rd_data = r_rd_vld ? r_rd : t_entry'{status: ST_UNSTARTED, start: '0};

endmodule

>>> hw/rtl/tpd_ctrl.sv
`timescale 1ns / 1ps
// Request sequencer: scans the task table one entry a cycle, read-modify-write.
// Holds the phase flag and the pending result. Depends on tpd_pkg.
module tpd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  tpd_pkg::t_request i_req,
    input  tpd_pkg::t_count   i_map_cnt,
    input  tpd_pkg::t_count   i_red_cnt,
    input  tpd_pkg::t_count   i_parts,
    input  tpd_pkg::t_time    i_timeout,
    output logic              o_idle,
    output tpd_pkg::t_addr    o_rd_addr,
    input  tpd_pkg::t_entry   i_rd_data,
    output tpd_pkg::t_mem_wr  o_wr,
    output logic              o_res_vld,
    output tpd_pkg::t_result  o_res,
    input  logic              i_res_rdy
);
    import tpd_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RESP} t_state;

    t_state   r_state,   n_state;
    t_request r_req,     n_req;
    logic     r_tbl,     n_tbl;
    t_count   r_rd_idx,  n_rd_idx;
    logic     r_chk_vld, n_chk_vld;
    t_idx     r_chk_idx, n_chk_idx;
    t_count   r_lim,     n_lim;
    logic     r_any,     n_any;
    logic     r_all,     n_all;
    logic     r_phase,   n_phase;
    t_result  r_res,     n_res;

    t_count   ack_lim;
    logic     last;
    logic     all_now;
    t_time    age;

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_tbl     = r_tbl;
        n_rd_idx  = r_rd_idx;
        n_chk_vld = 1'b0;
        n_chk_idx = r_chk_idx;
        n_lim     = r_lim;
        n_any     = r_any;
        n_all     = r_all;
        n_phase   = r_phase;
        n_res     = r_res;
        o_rd_addr = {r_tbl, r_rd_idx[IDX_W-1:0]};
        o_wr      = '0;
        ack_lim   = i_req.kind ? i_red_cnt : i_map_cnt;
        last      = ({1'b0, r_chk_idx} == (r_lim - t_count'(1)));
        all_now   = r_all && (i_rd_data.status == ST_FINISHED);
        age       = r_req.now - i_rd_data.start;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req    = i_req;
                    n_res    = '0;
                    n_rd_idx = '0;
                    n_any    = 1'b0;
                    n_all    = 1'b1;
                    n_tbl    = 1'b0;
                    n_lim    = i_map_cnt;
                    priority case (i_req.req)
                        REQ_ASK: begin
                            n_tbl       = r_phase;
                            n_lim       = r_phase ? i_red_cnt : i_map_cnt;
                            n_res.kind  = r_phase;
                            n_res.parts = i_parts;
                            n_state     = S_SCAN;
                        end
                        REQ_ACK: begin
                            if ({1'b0, i_req.idx} >= ack_lim) begin
                                n_res.code = RES_BAD;
                                n_state    = S_RESP;
                            end else begin
                                o_wr.we          = 1'b1;
                                o_wr.addr        = {i_req.kind, i_req.idx};
                                o_wr.data.status = ST_FINISHED;
                                o_wr.data.start  = '0;
                                // a map ack checks the whole map table for the phase switch
                                n_state = i_req.kind ? S_RESP : S_SCAN;
                            end
                        end
                        REQ_DONE: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // issue the next read while the previous entry is checked
                if (r_rd_idx < r_lim) begin
                    n_rd_idx  = r_rd_idx + t_count'(1);
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_rd_idx[IDX_W-1:0];
                end
                if (r_chk_vld) begin
                    priority case (r_req.req)
                        REQ_ASK: begin
                            if (i_rd_data.status == ST_UNSTARTED) begin
                                o_wr.we          = 1'b1;
                                o_wr.addr        = {r_tbl, r_chk_idx};
                                o_wr.data.status = ST_PENDING;
                                o_wr.data.start  = r_req.now;
                                n_res.code       = RES_OK;
                                n_res.idx        = r_chk_idx;
                                n_state          = S_RESP;
                            end else begin
                                n_any = r_any || (i_rd_data.status == ST_PENDING);
                                if (last) begin
                                    n_res.code = (r_phase && n_any) ? RES_BUSY : RES_NONE;
                                    n_state    = S_RESP;
                                end
                            end
                        end
                        REQ_ACK: begin
                            n_all = all_now;
                            if (last) begin
                                if (all_now) begin
                                    n_phase = 1'b1;
                                end
                                n_res.code = RES_OK;
                                n_state    = S_RESP;
                            end
                        end
                        default: begin
                            n_all = all_now;
                            if (i_rd_data.status == ST_PENDING && age >= i_timeout) begin
                                o_wr.we          = 1'b1;
                                o_wr.addr        = {r_tbl, r_chk_idx};
                                o_wr.data.status = ST_UNSTARTED;
                                o_wr.data.start  = i_rd_data.start;
                            end
                            if (last) begin
                                if (!r_tbl && all_now) begin
                                    // map all finished: advance to the reduce table
                                    n_tbl     = 1'b1;
                                    n_rd_idx  = '0;
                                    n_lim     = i_red_cnt;
                                    n_chk_vld = 1'b0;
                                end else begin
                                    n_res.all_done = all_now;
                                    n_state        = S_RESP;
                                end
                            end
                        end
                    endcase
                end
            end

            S_RESP: begin
                if (i_res_rdy) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_chk_vld <= 1'b0;
            r_phase   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= n_chk_vld;
            r_phase   <= n_phase;
        end
        r_req     <= n_req;
        r_tbl     <= n_tbl;
        r_rd_idx  <= n_rd_idx;
        r_chk_idx <= n_chk_idx;
        r_lim     <= n_lim;
        r_any     <= n_any;
        r_all     <= n_all;
        r_res     <= n_res;
    end

    assign o_idle    = (r_state == S_IDLE);
    assign o_res_vld = (r_state == S_RESP);
    assign o_res     = r_res;

    a_no_write_in_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP) |-> !o_wr.we)
        else $error("table written while a result waits");

    a_phase_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |=> r_phase)
        else $error("reduce phase left");

    a_scan_wr_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && o_wr.we) |-> (o_wr.addr == {r_tbl, r_chk_idx}))
        else $error("scan write-back to wrong entry");

    a_grant_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_req.req == REQ_ASK && r_res.code == RES_OK)
        |-> ({1'b0, r_res.idx} < r_lim))
        else $error("grant beyond task count");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_vld |-> ({1'b0, r_chk_idx} < r_lim))
        else $error("checked entry beyond task count");

endmodule

>>> hw/rtl/two_phase_task_dispatcher_core.sv
`timescale 1ns / 1ps
// Top level of the two-phase task dispatcher: configuration registers, output
// register and the wiring of sequencer and task memory. Depends on tpd_pkg,
// tpd_task_ram and tpd_ctrl.
//
//  channel   direction  tdata                               tuser
//  s_axis    in         [5:0] task_index, [37:6] now        [1:0] req_type, [2] task_kind
//  m_axis    out        [5:0] granted_index, [12:6]         [1:0] result_code,
//                       partitions_out, [13] all_done       [2] granted_kind
//  cfg       in         i_cfg_addr register index, i_cfg_wdata value, i_cfg_we strobe
//
// Ask: the memory read port checks one entry a cycle, from the first entry up to the
// granted one or to the task count of the phase.
// Map ack: a scan of the map table; reduce ack, bad index and unknown type: no scan.
// Done query: map table, then reduce table if the map is all finished; idle after each item.
// Reset is synchronous; per-entry valid bits clear the tables at once, no clearing pass.
// A result waits in the output register; the next item is taken meanwhile, but its
// own result holds the sequencer until the register is free.
module two_phase_task_dispatcher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [5:0] task_index, [37:6] now, [39:38] zero
    input  logic [2:0]  s_axis_tuser,   // [1:0] req_type, [2] task_kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [5:0] granted_index, [12:6] partitions_out,
                                        // [13] all_done, [15:14] zero
    output logic [2:0]  m_axis_tuser,   // [1:0] result_code, [2] granted_kind
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata
);
    import tpd_pkg::*;

    t_count   r_map_cnt;
    t_count   r_red_cnt;
    t_count   r_parts;
    t_time    r_timeout;
    logic     r_out_vld;
    t_result  r_out;

    t_request req;
    logic     start;
    logic     idle;
    logic     slot_free;
    logic     res_vld;
    t_result  res;
    t_addr    rd_addr;
    t_entry   rd_data;
    t_mem_wr  wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_cnt <= t_count'(MAX_TASKS);
            r_red_cnt <= t_count'(MAX_TASKS);
            r_parts   <= '0;
            r_timeout <= t_time'(10);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_MAP_CNT: r_map_cnt <= i_cfg_wdata[CNT_W-1:0];
                REG_RED_CNT: r_red_cnt <= i_cfg_wdata[CNT_W-1:0];
                REG_PARTS:   r_parts   <= i_cfg_wdata[CNT_W-1:0];
                REG_TIMEOUT: r_timeout <= i_cfg_wdata[TIME_W-1:0];
                default:     r_timeout <= r_timeout;
            endcase
        end
    end

    assign req.req  = s_axis_tuser[1:0];
    assign req.kind = s_axis_tuser[2];
    assign req.idx  = s_axis_tdata[IDX_W-1:0];
    assign req.now  = s_axis_tdata[IDX_W+TIME_W-1:IDX_W];

    assign s_axis_tready = idle;
    assign start         = s_axis_tvalid && idle;
    assign slot_free     = !r_out_vld || m_axis_tready;

    tpd_task_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr      (wr)
    );

    tpd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_req     (req),
        .i_map_cnt (clamp_count(r_map_cnt)),
        .i_red_cnt (clamp_count(r_red_cnt)),
        .i_parts   (r_parts),
        .i_timeout (r_timeout),
        .o_idle    (idle),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr      (wr),
        .o_res_vld (res_vld),
        .o_res     (res),
        .i_res_rdy (slot_free)
    );

    // output register: load when free or being taken, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_vld && slot_free) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
        if (res_vld && slot_free) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_out.all_done, r_out.parts, r_out.idx};
    assign m_axis_tuser  = {r_out.kind, r_out.code};

endmodule

>>> bench/two_phase_task_dispatcher_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for two_phase_task_dispatcher_core: directed and random
// asks, acks and done queries, scored against a local model of the task tables.
// Depends on tpd_pkg and the dispatcher RTL.
module two_phase_task_dispatcher_core_test;

    import tpd_pkg::*;

    localparam t_code REQ_UNUSED     = 2'd3;
    localparam int    HOLD_CYCLES    = 300;
    localparam int    WATCHDOG_LIMIT = 2000;
    localparam int    SETTLE_CYCLES  = 4;
    localparam int    DRAIN_CYCLES   = 200;
    localparam int    MAX_REPORTS    = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // [5:0] task_index, [37:6] now, [39:38] zero
    logic [2:0]  s_axis_tuser;   // [1:0] req_type, [2] task_kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [5:0] granted_index, [12:6] partitions_out,
                                 // [13] all_done, [15:14] zero
    logic [2:0]  m_axis_tuser;   // [1:0] result_code, [2] granted_kind
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [31:0] i_cfg_wdata;

    // local copy of the dispatcher state; side 0 is map, side 1 is reduce
    t_code  task_state [2][MAX_TASKS];
    t_time  task_stamp [2][MAX_TASKS];
    bit     reduce_phase;
    t_count cfg_map_cnt;
    t_count cfg_red_cnt;
    t_count cfg_parts;
    t_time  cfg_timeout;

    t_result awaited_replies[$];
    t_time   clock_now = 32'hFFFF_FF00;
    int      faults;
    int      quiet_cycles;
    int      holds_asked;
    int      holds_served;
    bit      steady_flow;

    two_phase_task_dispatcher_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int live_count(input int side);
        t_count raw;
        raw = side ? cfg_red_cnt : cfg_map_cnt;
        if (raw == '0) return 1;
        if (raw > MAX_TASKS) return MAX_TASKS;
        return int'(raw);
    endfunction

    // report whether every task in use on one side is finished, optionally
    // returning stale pending tasks to unstarted on the way
    function automatic bit table_finished(input int side, input t_time now, input bit reclaim);
        bit    settled;
        int    i;
        t_time age;
        settled = 1'b1;
        for (i = 0; i < live_count(side); i++) begin
            if (task_state[side][i] != ST_FINISHED) settled = 1'b0;
            age = now - task_stamp[side][i];
            if (reclaim && task_state[side][i] == ST_PENDING && age >= cfg_timeout)
                task_state[side][i] = ST_UNSTARTED;
        end
        return settled;
    endfunction

    function automatic t_result dispatch_reply(input t_code req, input logic kind,
                                               input t_idx idx, input t_time now);
        t_result r;
        int      ph;
        int      i;
        bit      granted;
        bit      busy;
        r = '0;
        ph = int'(reduce_phase);
        granted = 1'b0;
        busy = 1'b0;
        case (req)
            REQ_ASK: begin
                r.kind  = reduce_phase;
                r.parts = cfg_parts;
                for (i = 0; i < live_count(ph) && !granted; i++) begin
                    if (task_state[ph][i] == ST_UNSTARTED) begin
                        task_state[ph][i] = ST_PENDING;
                        task_stamp[ph][i] = now;
                        r.idx = t_idx'(i);
                        granted = 1'b1;
                    end else if (task_state[ph][i] == ST_PENDING) begin
                        busy = 1'b1;
                    end
                end
                if (!granted) r.code = (reduce_phase && busy) ? RES_BUSY : RES_NONE;
            end
            REQ_ACK: begin
                if (int'(idx) >= live_count(int'(kind))) begin
                    r.code = RES_BAD;
                end else begin
                    task_state[kind][idx] = ST_FINISHED;
                    if (kind == 1'b0 && table_finished(0, now, 1'b0)) reduce_phase = 1'b1;
                end
            end
            REQ_DONE: begin
                // the reduce table is only swept once the map table is all finished
                r.all_done = table_finished(0, now, 1'b1);
                if (r.all_done) r.all_done = table_finished(1, now, 1'b1);
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_time next_now();
        case ($urandom_range(0, 19))
            0: clock_now = $urandom();
            1: clock_now += $urandom_range(20, 500);
            default: clock_now += $urandom_range(0, 4);
        endcase
        return clock_now;
    endfunction

    // offer one item, hold it until taken, then log its reply
    task automatic issue_request(input t_code req, input logic kind, input t_idx idx,
                                 input t_time now);
        if (!steady_flow && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, now, idx};
        s_axis_tuser  <= {kind, req};
        do @(posedge i_clk); while (!s_axis_tready);
        awaited_replies.push_back(dispatch_reply(req, kind, idx, now));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] which, input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= which;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (which)
            REG_MAP_CNT: cfg_map_cnt = t_count'(value);
            REG_RED_CNT: cfg_red_cnt = t_count'(value);
            REG_PARTS:   cfg_parts   = t_count'(value);
            REG_TIMEOUT: cfg_timeout = value;
            default: ;
        endcase
    endtask

    task automatic shuffle_config(input bit reduce_side);
        int lead;
        int cnt;
        logic [31:0] limit;
        wait_idle();
        lead = 0;
        while (lead < MAX_TASKS && task_state[1][lead] == ST_FINISHED) lead++;
        if (reduce_side) begin
            // keep the map table finished most of the time so the reduce sweep runs
            cnt = ($urandom_range(0, 7) == 0) ? MAX_TASKS : $urandom_range(0, 3);
            write_reg(REG_MAP_CNT, cnt);
            case ($urandom_range(0, 7))
                0: cnt = 0;
                1: cnt = $urandom_range(MAX_TASKS + 1, 127);
                2: cnt = MAX_TASKS;
                default: begin
                    cnt = lead + $urandom_range(1, 6);
                    if (cnt > MAX_TASKS) cnt = MAX_TASKS;
                end
            endcase
            write_reg(REG_RED_CNT, cnt);
        end else begin
            case ($urandom_range(0, 5))
                0: cnt = 0;
                1: cnt = $urandom_range(MAX_TASKS + 1, 127);
                default: cnt = $urandom_range(1, MAX_TASKS);
            endcase
            write_reg(REG_MAP_CNT, cnt);
            write_reg(REG_RED_CNT, $urandom_range(0, 127));
        end
        write_reg(REG_PARTS, $urandom_range(0, 127));
        case ($urandom_range(0, 9))
            0: limit = '0;
            1: limit = 32'hFFFF_FFFF;
            2: limit = $urandom();
            default: limit = $urandom_range(1, 40);
        endcase
        write_reg(REG_TIMEOUT, limit);
    endtask

    task automatic random_request();
        t_code req;
        logic  kind;
        t_idx  idx;
        int    roll;
        int    i;
        int    picks[$];
        roll = $urandom_range(0, 99);
        kind = 1'($urandom_range(0, 1));
        idx  = t_idx'($urandom_range(0, 63));
        if (roll < 40) begin
            req = REQ_ASK;
        end else if (roll < 55) begin
            req = REQ_ACK;
            kind = reduce_phase;
            if ($urandom_range(0, 19) == 0) kind = !kind;
            if ($urandom_range(0, 9) < 7) begin
                for (i = 0; i < live_count(int'(kind)); i++)
                    if (task_state[kind][i] == ST_PENDING) picks.push_back(i);
                if (picks.size() != 0)
                    idx = t_idx'(picks[$urandom_range(0, picks.size() - 1)]);
            end
            // keep map task 0 open so the map phase lasts until the switch test
            if (!reduce_phase && kind == 1'b0 && idx == '0)
                idx = t_idx'($urandom_range(1, 63));
        end else if (roll < 94) begin
            req = REQ_DONE;
        end else begin
            req = REQ_UNUSED;
        end
        issue_request(req, kind, idx, next_now());
    endtask

    task automatic test_defaults();
        issue_request(REQ_DONE, 1'b0, '0, 32'd0);
        issue_request(REQ_ASK, 1'b0, '0, 32'd100);
        issue_request(REQ_ASK, 1'b1, 6'd63, 32'd101);
        issue_request(REQ_DONE, 1'b0, '0, 32'd109);
        issue_request(REQ_DONE, 1'b0, '0, 32'd110);
        issue_request(REQ_ASK, 1'b0, '0, 32'd111);
        issue_request(REQ_ACK, 1'b0, 6'd63, 32'hFFFF_FFFF);
        issue_request(REQ_UNUSED, 1'b1, 6'd63, 32'hFFFF_FFFF);
    endtask

    task automatic test_register_extremes();
        wait_idle();
        write_reg(REG_MAP_CNT, 32'd0);
        write_reg(REG_RED_CNT, 32'd127);
        write_reg(REG_PARTS, 32'd64);
        write_reg(REG_TIMEOUT, 32'd0);
        issue_request(REQ_ASK, 1'b0, '0, 32'd200);
        issue_request(REQ_ACK, 1'b0, 6'd1, 32'd200);
        issue_request(REQ_ACK, 1'b1, 6'd63, 32'd200);
        issue_request(REQ_DONE, 1'b0, '0, 32'd200);
        issue_request(REQ_ASK, 1'b0, '0, 32'd201);
        wait_idle();
        write_reg(REG_MAP_CNT, 32'd127);
        write_reg(REG_RED_CNT, 32'd1);
        write_reg(REG_PARTS, 32'd127);
        write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
        issue_request(REQ_ASK, 1'b0, '0, 32'd300);
        issue_request(REQ_ACK, 1'b1, 6'd1, 32'd300);
        // one tick behind the stamp: the age wraps to the largest value
        issue_request(REQ_DONE, 1'b0, '0, 32'd299);
        wait_idle();
        write_reg(REG_TIMEOUT, 32'd10);
        issue_request(REQ_ASK, 1'b0, '0, 32'hFFFF_FFF8);
        issue_request(REQ_DONE, 1'b0, '0, 32'd2);
    endtask

    task automatic test_map_traffic();
        repeat (9) begin
            shuffle_config(1'b0);
            repeat (50) random_request();
        end
    endtask

    task automatic test_back_pressure();
        holds_asked++;
        repeat (30) random_request();
    endtask

    task automatic test_phase_switch();
        wait_idle();
        write_reg(REG_MAP_CNT, 32'd3);
        write_reg(REG_RED_CNT, 32'd4);
        write_reg(REG_TIMEOUT, 32'd20);
        issue_request(REQ_ACK, 1'b0, 6'd1, next_now());
        issue_request(REQ_ACK, 1'b0, 6'd2, next_now());
        issue_request(REQ_DONE, 1'b0, '0, next_now());
        issue_request(REQ_ACK, 1'b0, 6'd0, next_now());
        issue_request(REQ_ASK, 1'b0, '0, next_now());
        issue_request(REQ_ASK, 1'b0, '0, next_now());
        issue_request(REQ_ACK, 1'b1, 6'd0, next_now());
        issue_request(REQ_DONE, 1'b0, '0, next_now());
    endtask

    task automatic test_reduce_traffic();
        repeat (9) begin
            shuffle_config(1'b1);
            repeat (50) random_request();
        end
    endtask

    task automatic test_steady_stream();
        wait_idle();
        steady_flow = 1'b1;
        repeat (60) random_request();
    endtask

    // receiver pacing: short random stalls, and a long hold when one is asked for
    initial begin : rx_pace
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served != holds_asked) begin
                holds_served++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!steady_flow && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : score_replies
        t_result seen;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.code     = m_axis_tuser[1:0];
            seen.kind     = m_axis_tuser[2];
            seen.idx      = m_axis_tdata[5:0];
            seen.parts    = m_axis_tdata[12:6];
            seen.all_done = m_axis_tdata[13];
            if (awaited_replies.size() == 0) begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("unexpected item: code %0d kind %0d index %0d parts %0d done %0d",
                             seen.code, seen.kind, seen.idx, seen.parts, seen.all_done);
            end else begin
                want = awaited_replies.pop_front();
                if (seen.code !== want.code || seen.kind !== want.kind ||
                    seen.idx !== want.idx || seen.parts !== want.parts ||
                    seen.all_done !== want.all_done) begin
                    faults++;
                    if (faults <= MAX_REPORTS) begin
                        $display("reply mismatch: expected code %0d kind %0d index %0d parts %0d done %0d",
                                 want.code, want.kind, want.idx, want.parts, want.all_done);
                        $display("                got code %0d kind %0d index %0d parts %0d done %0d",
                                 seen.code, seen.kind, seen.idx, seen.parts, seen.all_done);
                    end
                end
            end
        end
    end

    // stop a hung run: count cycles in which no item moves on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : run
        int side;
        int i;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_wdata   <= '0;
        for (side = 0; side < 2; side++) begin
            for (i = 0; i < MAX_TASKS; i++) begin
                task_state[side][i] = ST_UNSTARTED;
                task_stamp[side][i] = '0;
            end
        end
        reduce_phase = 1'b0;
        cfg_map_cnt  = t_count'(MAX_TASKS);
        cfg_red_cnt  = t_count'(MAX_TASKS);
        cfg_parts    = '0;
        cfg_timeout  = 32'd10;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults();
        test_register_extremes();
        test_map_traffic();
        test_back_pressure();
        test_phase_switch();
        test_reduce_traffic();
        test_steady_stream();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (faults == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/tpd_pkg.sv
hw/rtl/tpd_task_ram.sv
hw/rtl/tpd_ctrl.sv
hw/rtl/two_phase_task_dispatcher_core.sv
bench/two_phase_task_dispatcher_core_test.sv
